@@ hdl/rv64_instruction_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// RV64 instruction decoder assertion macros
// Shared concurrent assertion forms used by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef RV64_INSTRUCTION_DECODER_MACROS_SVH
`define RV64_INSTRUCTION_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RV64ID_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rv64id checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define RV64ID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rv64id checker: next-cycle property failed");

`endif

@@ hdl/rv64id_pkg.sv @@
// ----------------------------------------------------------------------------
// RV64 instruction decoder package
// Types, opcode and format codes, and queue sizing shared by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rv64id_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] OP_LAST = 7'd113;

    localparam logic [2:0] FMT_R  = 3'd0;
    localparam logic [2:0] FMT_R4 = 3'd1;
    localparam logic [2:0] FMT_I  = 3'd2;
    localparam logic [2:0] FMT_S  = 3'd3;
    localparam logic [2:0] FMT_B  = 3'd4;
    localparam logic [2:0] FMT_U  = 3'd5;
    localparam logic [2:0] FMT_J  = 3'd6;

    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
    localparam logic [6:0] OPC_OP_IMM   = 7'h13;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_FSTORE   = 7'h27;
    localparam logic [6:0] OPC_AMO      = 7'h2F;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_OP32     = 7'h3B;
    localparam logic [6:0] OPC_MADD     = 7'h43;
    localparam logic [6:0] OPC_MSUB     = 7'h47;
    localparam logic [6:0] OPC_NMSUB    = 7'h4B;
    localparam logic [6:0] OPC_NMADD    = 7'h4F;
    localparam logic [6:0] OPC_OP_FP    = 7'h53;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_JAL      = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;

    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_OP_IMM,
        CLS_OP_IMM32,
        CLS_LOAD,
        CLS_OP_FP,
        CLS_AMO,
        CLS_OP32,
        CLS_OP,
        CLS_STORE,
        CLS_FSTORE,
        CLS_BRANCH,
        CLS_LUI,
        CLS_AUIPC,
        CLS_JAL
    } rv64id_class_t;

    typedef struct packed {
        logic [31:0]   word;
        logic [2:0]    fmt;
        rv64id_class_t cls;
    } rv64id_entry_t;

    typedef struct packed {
        logic          valid;
        rv64id_entry_t entry;
    } rv64id_slot_t;

endpackage

`default_nettype wire

@@ hdl/rv64id_front.sv @@
// ----------------------------------------------------------------------------
// RV64 instruction decoder front end
// Classifies an incoming word by its major opcode into format and class.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64id_front (
    input  wire logic                  instruction_valid,
    input  wire logic [31:0]           instruction,
    output rv64id_pkg::rv64id_slot_t   push
);

    logic [2:0]                fmt;
    rv64id_pkg::rv64id_class_t cls;

    always_comb
    begin
        fmt = rv64id_pkg::FMT_R;
        cls = rv64id_pkg::CLS_NONE;
        unique case (instruction[6:0])
            rv64id_pkg::OPC_OP_FP:
            begin
                fmt = rv64id_pkg::FMT_R;
                cls = rv64id_pkg::CLS_OP_FP;
            end
            rv64id_pkg::OPC_OP:
            begin
                fmt = rv64id_pkg::FMT_R;
                cls = rv64id_pkg::CLS_OP;
            end
            rv64id_pkg::OPC_OP32:
            begin
                fmt = rv64id_pkg::FMT_R;
                cls = rv64id_pkg::CLS_OP32;
            end
            rv64id_pkg::OPC_AMO:
            begin
                fmt = rv64id_pkg::FMT_R;
                cls = rv64id_pkg::CLS_AMO;
            end
            rv64id_pkg::OPC_MADD, rv64id_pkg::OPC_MSUB,
            rv64id_pkg::OPC_NMSUB, rv64id_pkg::OPC_NMADD:
            begin
                fmt = rv64id_pkg::FMT_R4;
            end
            rv64id_pkg::OPC_LOAD:
            begin
                fmt = rv64id_pkg::FMT_I;
                cls = rv64id_pkg::CLS_LOAD;
            end
            rv64id_pkg::OPC_OP_IMM:
            begin
                fmt = rv64id_pkg::FMT_I;
                cls = rv64id_pkg::CLS_OP_IMM;
            end
            rv64id_pkg::OPC_OP_IMM32:
            begin
                fmt = rv64id_pkg::FMT_I;
                cls = rv64id_pkg::CLS_OP_IMM32;
            end
            rv64id_pkg::OPC_MISC_MEM, rv64id_pkg::OPC_JALR, rv64id_pkg::OPC_SYSTEM:
            begin
                fmt = rv64id_pkg::FMT_I;
            end
            rv64id_pkg::OPC_STORE:
            begin
                fmt = rv64id_pkg::FMT_S;
                cls = rv64id_pkg::CLS_STORE;
            end
            rv64id_pkg::OPC_FSTORE:
            begin
                fmt = rv64id_pkg::FMT_S;
                cls = rv64id_pkg::CLS_FSTORE;
            end
            rv64id_pkg::OPC_BRANCH:
            begin
                fmt = rv64id_pkg::FMT_B;
                cls = rv64id_pkg::CLS_BRANCH;
            end
            rv64id_pkg::OPC_LUI:
            begin
                fmt = rv64id_pkg::FMT_U;
                cls = rv64id_pkg::CLS_LUI;
            end
            rv64id_pkg::OPC_AUIPC:
            begin
                fmt = rv64id_pkg::FMT_U;
                cls = rv64id_pkg::CLS_AUIPC;
            end
            rv64id_pkg::OPC_JAL:
            begin
                fmt = rv64id_pkg::FMT_J;
                cls = rv64id_pkg::CLS_JAL;
            end
            default:
            begin
                fmt = rv64id_pkg::FMT_R;
                cls = rv64id_pkg::CLS_NONE;
            end
        endcase
    end

    assign push.valid       = instruction_valid;
    assign push.entry.word  = instruction;
    assign push.entry.fmt   = fmt;
    assign push.entry.cls   = cls;

endmodule

`default_nettype wire

@@ hdl/rv64id_queue.sv @@
// ----------------------------------------------------------------------------
// RV64 instruction decoder queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64id_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  rv64id_pkg::rv64id_slot_t push,
    output logic                     full,
    output rv64id_pkg::rv64id_slot_t head,
    input  wire logic                pop
);

    rv64id_pkg::rv64id_entry_t              store_reg [rv64id_pkg::QUEUE_DEPTH];
    logic [rv64id_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [rv64id_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [rv64id_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [rv64id_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [rv64id_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic [rv64id_pkg::QUEUE_CNT_W-1:0]     count_next;
    logic                                   do_push;
    logic                                   do_pop;

    assign full       = (count_reg == rv64id_pkg::QUEUE_CNT_W'(rv64id_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = store_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == rv64id_pkg::QUEUE_PTR_W'(rv64id_pkg::QUEUE_DEPTH - 1))
            begin
                wr_ptr_next = '0;
            end
            else
            begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == rv64id_pkg::QUEUE_PTR_W'(rv64id_pkg::QUEUE_DEPTH - 1))
            begin
                rd_ptr_next = '0;
            end
            else
            begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rv64id_back.sv @@
// ----------------------------------------------------------------------------
// RV64 instruction decoder back end
// Selects the operation number and immediate and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64id_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  rv64id_pkg::rv64id_slot_t head,
    output logic                     pop,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic                     illegal,
    output logic [2:0]               format,
    output logic [6:0]               operation,
    output logic [4:0]               dest_reg,
    output logic [4:0]               src_reg1,
    output logic [4:0]               src_reg2,
    output logic [4:0]               src_reg3,
    output logic [2:0]               funct3_field,
    output logic [6:0]               funct7_field,
    output logic signed [31:0]       immediate
);

    logic [31:0]        w;
    logic [2:0]         f3;
    logic [6:0]         f7;
    logic [4:0]         rs2;
    logic [4:0]         f5;
    logic [5:0]         f6;
    logic               ok;
    logic [6:0]         op;
    logic [6:0]         base;
    logic [6:0]         amo_base;
    logic               pair;
    logic [31:0]        imm;

    logic               valid_reg;
    logic               valid_next;
    logic               illegal_reg;
    logic [2:0]         format_reg;
    logic [6:0]         operation_reg;
    logic [31:0]        word_reg;
    logic [31:0]        imm_reg;

    assign w   = head.entry.word;
    assign f3  = w[14:12];
    assign f7  = w[31:25];
    assign rs2 = w[24:20];
    assign f5  = w[31:27];
    assign f6  = w[31:26];

    always_comb
    begin
        unique case (f3)
            3'd0:    base = 7'd80;
            3'd1:    base = 7'd83;
            3'd2:    base = 7'd85;
            3'd3:    base = 7'd87;
            3'd4:    base = 7'd89;
            3'd5:    base = 7'd91;
            3'd6:    base = 7'd94;
            default: base = 7'd96;
        endcase
        pair     = (f3 == 3'd0) || (f3 == 3'd5);
        amo_base = (f3 == 3'd2) ? 7'd48 : 7'd59;
    end

    always_comb
    begin
        ok = 1'b0;
        op = 7'd0;
        unique case (head.entry.cls)
            rv64id_pkg::CLS_OP_IMM:
            begin
                ok = 1'b1;
                unique case (f3)
                    3'd0: op = 7'd0;
                    3'd2: op = 7'd1;
                    3'd3: op = 7'd2;
                    3'd4: op = 7'd3;
                    3'd6: op = 7'd4;
                    3'd7: op = 7'd5;
                    3'd1:
                    begin
                        ok = (f6 == 6'h00);
                        op = 7'd6;
                    end
                    default:
                    begin
                        ok = (f6 == 6'h00) || (f6 == 6'h10);
                        op = (f6 == 6'h10) ? 7'd8 : 7'd7;
                    end
                endcase
            end
            rv64id_pkg::CLS_OP_IMM32:
            begin
                if (f3 == 3'd0)
                begin
                    ok = 1'b1;
                    op = 7'd9;
                end
                else if (f3 == 3'd1)
                begin
                    ok = (f7 == 7'h00);
                    op = 7'd10;
                end
                else if (f3 == 3'd5)
                begin
                    ok = (f7 == 7'h00) || (f7 == 7'h20);
                    op = (f7 == 7'h20) ? 7'd12 : 7'd11;
                end
            end
            rv64id_pkg::CLS_LOAD:
            begin
                ok = 1'b1;
                unique case (f3)
                    3'd0: op = 7'd13;
                    3'd1: op = 7'd14;
                    3'd2: op = 7'd15;
                    3'd4: op = 7'd16;
                    3'd5: op = 7'd17;
                    3'd6: op = 7'd18;
                    3'd3: op = 7'd19;
                    default: ok = 1'b0;
                endcase
            end
            rv64id_pkg::CLS_OP_FP:
            begin
                ok = 1'b1;
                unique case (f7)
                    7'h01: op = 7'd20;
                    7'h05: op = 7'd21;
                    7'h09: op = 7'd22;
                    7'h0D: op = 7'd23;
                    7'h2D: op = 7'd24;
                    7'h79: op = 7'd25;
                    7'h20:
                    begin
                        ok = (rs2 == 5'd1) || (rs2 == 5'd3);
                        op = (rs2 == 5'd1) ? 7'd26 : 7'd27;
                    end
                    7'h21:
                    begin
                        ok = (rs2 == 5'd0) || (rs2 == 5'd3);
                        op = (rs2 == 5'd0) ? 7'd28 : 7'd29;
                    end
                    7'h61:
                    begin
                        ok = (rs2[4:2] == 3'd0);
                        op = 7'd30 + {5'd0, rs2[1:0]};
                    end
                    7'h69:
                    begin
                        ok = (rs2[4:2] == 3'd0);
                        op = 7'd34 + {5'd0, rs2[1:0]};
                    end
                    7'h11:
                    begin
                        ok = (f3 < 3'd3);
                        op = 7'd38 + {4'd0, f3};
                    end
                    7'h15:
                    begin
                        ok = (f3 < 3'd2);
                        op = 7'd41 + {4'd0, f3};
                    end
                    7'h51:
                    begin
                        ok = (f3 < 3'd3);
                        op = 7'd45 - {4'd0, f3};
                    end
                    7'h71:
                    begin
                        ok = (f3 < 3'd2);
                        op = 7'd47 - {4'd0, f3};
                    end
                    default: ok = 1'b0;
                endcase
            end
            rv64id_pkg::CLS_AMO:
            begin
                ok = (f3 == 3'd2) || (f3 == 3'd3);
                unique case (f5)
                    5'd0:  op = amo_base + 7'd3;
                    5'd1:  op = amo_base + 7'd2;
                    5'd2:  op = amo_base;
                    5'd3:  op = amo_base + 7'd1;
                    5'd4:  op = amo_base + 7'd4;
                    5'd8:  op = amo_base + 7'd6;
                    5'd12: op = amo_base + 7'd5;
                    5'd16: op = amo_base + 7'd7;
                    5'd20: op = amo_base + 7'd8;
                    5'd24: op = amo_base + 7'd9;
                    5'd28: op = amo_base + 7'd10;
                    default: ok = 1'b0;
                endcase
            end
            rv64id_pkg::CLS_OP32:
            begin
                unique case (f3)
                    3'd0:
                    begin
                        ok = (f7 == 7'h00) || (f7 == 7'h20) || (f7 == 7'h01);
                        op = (f7 == 7'h00) ? 7'd70 : (f7 == 7'h20) ? 7'd71 : 7'd72;
                    end
                    3'd5:
                    begin
                        ok = (f7 == 7'h00) || (f7 == 7'h20) || (f7 == 7'h01);
                        op = (f7 == 7'h00) ? 7'd73 : (f7 == 7'h20) ? 7'd74 : 7'd75;
                    end
                    3'd1:
                    begin
                        ok = (f7 == 7'h00);
                        op = 7'd76;
                    end
                    3'd4:
                    begin
                        ok = (f7 == 7'h01);
                        op = 7'd77;
                    end
                    3'd6:
                    begin
                        ok = (f7 == 7'h01);
                        op = 7'd78;
                    end
                    3'd7:
                    begin
                        ok = (f7 == 7'h01);
                        op = 7'd79;
                    end
                    default: ok = 1'b0;
                endcase
            end
            rv64id_pkg::CLS_OP:
            begin
                if (f7 == 7'h00)
                begin
                    ok = 1'b1;
                    op = base;
                end
                else if (f7 == 7'h20)
                begin
                    ok = pair;
                    op = base + 7'd1;
                end
                else if (f7 == 7'h01)
                begin
                    ok = 1'b1;
                    op = pair ? base + 7'd2 : base + 7'd1;
                end
            end
            rv64id_pkg::CLS_STORE:
            begin
                ok = (f3 < 3'd4);
                op = 7'd98 + {4'd0, f3};
            end
            rv64id_pkg::CLS_FSTORE:
            begin
                ok = (f3 == 3'd2) || (f3 == 3'd3) || (f3 == 3'd4);
                op = 7'd100 + {4'd0, f3};
            end
            rv64id_pkg::CLS_BRANCH:
            begin
                ok = (f3 != 3'd2) && (f3 != 3'd3);
                op = (f3 < 3'd2) ? 7'd105 + {4'd0, f3} : 7'd103 + {4'd0, f3};
            end
            rv64id_pkg::CLS_LUI:
            begin
                ok = 1'b1;
                op = 7'd111;
            end
            rv64id_pkg::CLS_AUIPC:
            begin
                ok = 1'b1;
                op = 7'd112;
            end
            rv64id_pkg::CLS_JAL:
            begin
                ok = 1'b1;
                op = 7'd113;
            end
            default:
            begin
                ok = 1'b0;
                op = 7'd0;
            end
        endcase
    end

    always_comb
    begin
        unique case (head.entry.fmt)
            rv64id_pkg::FMT_I: imm = {{20{w[31]}}, w[31:20]};
            rv64id_pkg::FMT_S: imm = {{20{w[31]}}, w[31:25], w[11:7]};
            rv64id_pkg::FMT_B: imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            rv64id_pkg::FMT_U: imm = {w[31:12], 12'd0};
            rv64id_pkg::FMT_J: imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            default:           imm = 32'd0;
        endcase
    end

    assign pop = head.valid && (!valid_reg || !result_stall);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            illegal_reg   <= !ok;
            format_reg    <= head.entry.fmt;
            operation_reg <= ok ? op : 7'd0;
            word_reg      <= w;
            imm_reg       <= imm;
        end
    end

    assign result_valid = valid_reg;
    assign illegal      = illegal_reg;
    assign format       = format_reg;
    assign operation    = operation_reg;
    assign dest_reg     = word_reg[11:7];
    assign src_reg1     = word_reg[19:15];
    assign src_reg2     = word_reg[24:20];
    assign src_reg3     = word_reg[31:27];
    assign funct3_field = word_reg[14:12];
    assign funct7_field = word_reg[31:25];
    assign immediate    = imm_reg;

endmodule

`default_nettype wire

@@ hdl/rv64_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// RV64 instruction decoder
// Decodes one RV64IMAD instruction word per transaction into a legality flag,
// format class, operation number, register and function fields, and the
// sign-extended immediate. The block accepts one transaction every clock
// cycle while the input is not stalled; the front end classifies the opcode
// into a two-entry queue, and the back end decodes the function fields into
// a result register. The input stalls only when the queue is full, which
// happens only after the output has been stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64_instruction_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               instruction_valid,
    output logic                    instruction_stall,
    input  wire logic [31:0]        instruction,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic                    illegal,
    output logic [2:0]              format,
    output logic [6:0]              operation,
    output logic [4:0]              dest_reg,
    output logic [4:0]              src_reg1,
    output logic [4:0]              src_reg2,
    output logic [4:0]              src_reg3,
    output logic [2:0]              funct3_field,
    output logic [6:0]              funct7_field,
    output logic signed [31:0]      immediate
);

    rv64id_pkg::rv64id_slot_t push;
    rv64id_pkg::rv64id_slot_t head;
    logic                     pop;
    logic                     full;

    rv64id_front u_front (
        .instruction_valid (instruction_valid),
        .instruction       (instruction),
        .push              (push)
    );

    rv64id_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .head  (head),
        .pop   (pop)
    );

    rv64id_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .illegal      (illegal),
        .format       (format),
        .operation    (operation),
        .dest_reg     (dest_reg),
        .src_reg1     (src_reg1),
        .src_reg2     (src_reg2),
        .src_reg3     (src_reg3),
        .funct3_field (funct3_field),
        .funct7_field (funct7_field),
        .immediate    (immediate)
    );

    assign instruction_stall = full;

endmodule

`default_nettype wire

@@ hdl/rv64id_checker.sv @@
// ----------------------------------------------------------------------------
// RV64 instruction decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rv64_instruction_decoder_macros.svh"

module rv64id_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               instruction_valid,
    input  wire logic               instruction_stall,
    input  wire logic [31:0]        instruction,
    input  wire logic               result_valid,
    input  wire logic               result_stall,
    input  wire logic               illegal,
    input  wire logic [2:0]         format,
    input  wire logic [6:0]         operation,
    input  wire logic [4:0]         dest_reg,
    input  wire logic [4:0]         src_reg1,
    input  wire logic [4:0]         src_reg2,
    input  wire logic [4:0]         src_reg3,
    input  wire logic [2:0]         funct3_field,
    input  wire logic [6:0]         funct7_field,
    input  wire logic signed [31:0] immediate
);

    `RV64ID_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && result_stall, result_valid)

    `RV64ID_ASSERT_SAME(a_illegal_op_zero, clk, rst_n, result_valid && illegal, operation == 7'd0)

    `RV64ID_ASSERT_SAME(a_op_in_range, clk, rst_n, result_valid, operation <= rv64id_pkg::OP_LAST)

    `RV64ID_ASSERT_SAME(a_r_type_no_imm, clk, rst_n, result_valid && (format == rv64id_pkg::FMT_R || format == rv64id_pkg::FMT_R4), immediate == 32'sd0)

endmodule

bind rv64_instruction_decoder rv64id_checker u_checker (.*);

`default_nettype wire
